// ----- hw/rtl/c2d_pkg.sv -----
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared types and constants of the strided, dilated 2-D convolution engine.
// ----------------------------------------------------------------------------
package c2d_pkg;

  // Default sizes of the stores.
  localparam int DefMaxRows    = 32;
  localparam int DefMaxCols    = 32;
  localparam int DefInChannels = 8;
  localparam int DefOutChannels = 8;
  localparam int DefKernelRows = 3;
  localparam int DefKernelCols = 3;

  // Item modes.
  localparam logic [1:0] MODE_MAP    = 2'd0;
  localparam logic [1:0] MODE_WEIGHT = 2'd1;
  localparam logic [1:0] MODE_POINT  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_MAP_HEIGHT = 3'd0;
  localparam logic [2:0] REG_MAP_WIDTH  = 3'd1;
  localparam logic [2:0] REG_STRIDE_R   = 3'd2;
  localparam logic [2:0] REG_STRIDE_C   = 3'd3;
  localparam logic [2:0] REG_PAD_R      = 3'd4;
  localparam logic [2:0] REG_PAD_C      = 3'd5;
  localparam logic [2:0] REG_DIL_R      = 3'd6;
  localparam logic [2:0] REG_DIL_C      = 3'd7;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 6;

  typedef struct packed {
    logic [1:0]        mode;
    logic [4:0]        map_row;
    logic [4:0]        map_col;
    logic [2:0]        in_chan;
    logic [2:0]        out_chan_sel;
    logic [1:0]        kern_row;
    logic [1:0]        kern_col;
    logic signed [15:0] elem_value;
    logic [5:0]        point_row;
    logic [5:0]        point_col;
  } c2d_in_t;

  typedef struct packed {
    logic [5:0]         res_row;
    logic [5:0]         res_col;
    logic [2:0]         res_chan;
    logic signed [15:0] sum_value;
    logic               last;
  } c2d_out_t;

  typedef struct packed {
    logic [5:0] map_height;
    logic [5:0] map_width;
    logic [3:0] stride_rows;
    logic [3:0] stride_cols;
    logic [3:0] pad_rows;
    logic [3:0] pad_cols;
    logic [3:0] dilation_rows;
    logic [3:0] dilation_cols;
  } c2d_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;     // an input item is taken this cycle
    logic       start;      // a compute item is taken this cycle
    logic       issue;      // one kernel tap is issued this cycle
    logic       first;      // first tap of an output channel
    logic       last;       // last tap of an output channel
    logic       last_chan;  // the channel is the final one of the point
    logic [2:0] kr;
    logic [2:0] kc;
    logic [5:0] chan;
  } c2d_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;       // a result is written to the output register
    logic out_busy;   // the output register holds a result
  } c2d_status_t;

endpackage

// ----- hw/rtl/conv2d_strided_dilated.sv -----
// ----------------------------------------------------------------------------
// conv2d_strided_dilated
// NHWC 2-D forward correlation with stride, padding and dilation in Q8.8.
// ----------------------------------------------------------------------------
// Map and weight load items are taken while the engine is idle and produce no
// result. A compute item produces one result per output channel and keeps the
// input stalled until the result of the last output channel is written to the
// output register; stalls on the output side lengthen this. Each output
// channel passes through a wait state, issues its kernel taps in turn and then
// drains through the product, sum, accumulate and rounding pipeline; every
// channel after the first stays in the wait state while the previous result
// still occupies the output register. Each tap is a multiply-accumulate across
// all input channels read in parallel from one map bank and one weight bank
// per input channel.
// Stores are not cleared; entries must be written before they are used.
// ----------------------------------------------------------------------------
module conv2d_strided_dilated import c2d_pkg::*; #(
  parameter int MAX_ROWS     = DefMaxRows,
  parameter int MAX_COLS     = DefMaxCols,
  parameter int IN_CHANNELS  = DefInChannels,
  parameter int OUT_CHANNELS = DefOutChannels,
  parameter int KERNEL_ROWS  = DefKernelRows,
  parameter int KERNEL_COLS  = DefKernelCols
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  c2d_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output c2d_out_t            out_data_o
);

  c2d_cfg_t    cfg_q;
  c2d_cmd_t    cmd;
  c2d_status_t status;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_height    <= 6'd32;
      cfg_q.map_width     <= 6'd32;
      cfg_q.stride_rows   <= 4'd1;
      cfg_q.stride_cols   <= 4'd1;
      cfg_q.pad_rows      <= 4'd0;
      cfg_q.pad_cols      <= 4'd0;
      cfg_q.dilation_rows <= 4'd1;
      cfg_q.dilation_cols <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MAP_HEIGHT: cfg_q.map_height    <= cfg_data_i;
        REG_MAP_WIDTH:  cfg_q.map_width     <= cfg_data_i;
        REG_STRIDE_R:   cfg_q.stride_rows   <= cfg_data_i[3:0];
        REG_STRIDE_C:   cfg_q.stride_cols   <= cfg_data_i[3:0];
        REG_PAD_R:      cfg_q.pad_rows      <= cfg_data_i[3:0];
        REG_PAD_C:      cfg_q.pad_cols      <= cfg_data_i[3:0];
        REG_DIL_R:      cfg_q.dilation_rows <= cfg_data_i[3:0];
        REG_DIL_C:      cfg_q.dilation_cols <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  c2d_ctrl #(
    .OutChannels (OUT_CHANNELS),
    .KernelRows  (KERNEL_ROWS),
    .KernelCols  (KERNEL_COLS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  c2d_dpath #(
    .MaxRows     (MAX_ROWS),
    .MaxCols     (MAX_COLS),
    .InChannels  (IN_CHANNELS),
    .OutChannels (OUT_CHANNELS),
    .KernelRows  (KERNEL_ROWS),
    .KernelCols  (KERNEL_COLS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hw/rtl/c2d_ram.sv -----
// ----------------------------------------------------------------------------
// c2d_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module c2d_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/c2d_ctrl.sv -----
// ----------------------------------------------------------------------------
// c2d_ctrl
// Controller: walks output channels and kernel taps of one compute item.
// ----------------------------------------------------------------------------
module c2d_ctrl import c2d_pkg::*; #(
  parameter int OutChannels = DefOutChannels,
  parameter int KernelRows  = DefKernelRows,
  parameter int KernelCols  = DefKernelCols
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [1:0]  in_mode_i,
  output logic        in_stall_o,
  input  c2d_status_t status_i,
  output c2d_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_RUN,
    ST_DRAIN
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] kr_q, kr_d;
  logic [2:0] kc_q, kc_d;
  logic [5:0] chan_q, chan_d;

  logic last_kr, last_kc, last_chan;

  assign last_kr   = (kr_q == 3'(KernelRows - 1));
  assign last_kc   = (kc_q == 3'(KernelCols - 1));
  assign last_chan = (chan_q == 6'(OutChannels - 1));

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    kr_d    = kr_q;
    kc_d    = kc_q;
    chan_d  = chan_q;
    cmd_o   = '0;
    cmd_o.kr        = kr_q;
    cmd_o.kc        = kc_q;
    cmd_o.chan      = chan_q;
    cmd_o.first     = (kr_q == 3'd0) && (kc_q == 3'd0);
    cmd_o.last      = last_kr && last_kc;
    cmd_o.last_chan = last_chan;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && (in_mode_i == MODE_POINT)) begin
          cmd_o.start = 1'b1;
          chan_d  = '0;
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        kr_d = '0;
        kc_d = '0;
        if (!status_i.out_busy) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (last_kc) begin
          kc_d = '0;
          kr_d = kr_q + 3'd1;
          if (last_kr) begin
            state_d = ST_DRAIN;
          end
        end else begin
          kc_d = kc_q + 3'd1;
        end
      end
      ST_DRAIN: begin
        if (status_i.done) begin
          if (last_chan) begin
            state_d = ST_IDLE;
          end else begin
            chan_d  = chan_q + 6'd1;
            state_d = ST_WAIT;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kr_q    <= '0;
      kc_q    <= '0;
      chan_q  <= '0;
    end else begin
      state_q <= state_d;
      kr_q    <= kr_d;
      kc_q    <= kc_d;
      chan_q  <= chan_d;
    end
  end

endmodule

// ----- hw/rtl/c2d_dpath.sv -----
// ----------------------------------------------------------------------------
// c2d_dpath
// Datapath: map and weight banks, tap address logic, channel-wide
// multiply-accumulate pipeline, rounding and the output register.
// ----------------------------------------------------------------------------
module c2d_dpath import c2d_pkg::*; #(
  parameter int MaxRows     = DefMaxRows,
  parameter int MaxCols     = DefMaxCols,
  parameter int InChannels  = DefInChannels,
  parameter int OutChannels = DefOutChannels,
  parameter int KernelRows  = DefKernelRows,
  parameter int KernelCols  = DefKernelCols
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  c2d_cfg_t    cfg_i,
  input  c2d_in_t     in_data_i,
  input  c2d_cmd_t    cmd_i,
  output c2d_status_t status_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output c2d_out_t    out_data_o
);

  localparam int MapDepth = MaxRows * MaxCols;
  localparam int WtDepth  = OutChannels * KernelRows * KernelCols;
  localparam int MapAw    = (MapDepth > 1) ? $clog2(MapDepth) : 1;
  localparam int WtAw     = (WtDepth > 1) ? $clog2(WtDepth) : 1;
  localparam int SumW     = 32 + $clog2(InChannels + 1);

  // ---- Loads into the banks ----
  logic             map_we, wt_we;
  logic [MapAw-1:0] map_waddr;
  logic [WtAw-1:0]  wt_waddr;

  always_comb begin
    map_we = cmd_i.accept && (in_data_i.mode == MODE_MAP) &&
             (int'(in_data_i.map_row) < MaxRows) &&
             (int'(in_data_i.map_col) < MaxCols) &&
             (int'(in_data_i.in_chan) < InChannels);
    wt_we  = cmd_i.accept && (in_data_i.mode == MODE_WEIGHT) &&
             (int'(in_data_i.out_chan_sel) < OutChannels) &&
             (int'(in_data_i.kern_row) < KernelRows) &&
             (int'(in_data_i.kern_col) < KernelCols) &&
             (int'(in_data_i.in_chan) < InChannels);
    map_waddr = MapAw'(int'(in_data_i.map_row) * MaxCols + int'(in_data_i.map_col));
    wt_waddr  = WtAw'((int'(in_data_i.out_chan_sel) * KernelRows + int'(in_data_i.kern_row))
                      * KernelCols + int'(in_data_i.kern_col));
  end

  // ---- Point registers and tap bases ----
  logic [5:0]         prow_q, pcol_q;
  logic signed [12:0] rbase_q, cbase_q;
  logic [WtAw-1:0]    widx_q;
  logic [5:0]         chan_q;
  logic               lastch_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      prow_q <= in_data_i.point_row;
      pcol_q <= in_data_i.point_col;
    end
    rbase_q <= $signed({3'b0, 10'(prow_q) * 10'(cfg_i.stride_rows)})
               - $signed({9'b0, cfg_i.pad_rows});
    cbase_q <= $signed({3'b0, 10'(pcol_q) * 10'(cfg_i.stride_cols)})
               - $signed({9'b0, cfg_i.pad_cols});
    if (cmd_i.start) begin
      widx_q <= '0;
    end else if (cmd_i.issue) begin
      widx_q <= widx_q + WtAw'(1);
    end
    if (cmd_i.issue && cmd_i.first) begin
      chan_q   <= cmd_i.chan;
      lastch_q <= cmd_i.last_chan;
    end
  end

  // ---- Tap position and bounds ----
  logic signed [12:0] tap_r, tap_c, height, width;
  logic               tap_ok;
  logic [MapAw-1:0]   map_raddr;

  always_comb begin
    tap_r  = rbase_q + $signed({6'b0, 7'(cmd_i.kr) * 7'(cfg_i.dilation_rows)});
    tap_c  = cbase_q + $signed({6'b0, 7'(cmd_i.kc) * 7'(cfg_i.dilation_cols)});
    height = (int'(cfg_i.map_height) > MaxRows) ? 13'(MaxRows) : $signed({7'b0, cfg_i.map_height});
    width  = (int'(cfg_i.map_width) > MaxCols) ? 13'(MaxCols) : $signed({7'b0, cfg_i.map_width});
    tap_ok = (tap_r >= 13'sd0) && (tap_r < height) && (tap_c >= 13'sd0) && (tap_c < width);
    map_raddr = MapAw'(int'(tap_r) * MaxCols + int'(tap_c));
  end

  // ---- Per-channel banks ----
  logic signed [15:0] map_rd [InChannels];
  logic signed [15:0] wt_rd  [InChannels];

  for (genvar g = 0; g < InChannels; g++) begin : g_bank
    c2d_ram #(.Width(16), .Depth(MapDepth)) u_map_ram (
      .clk_i   (clk_i),
      .we_i    (map_we && (int'(in_data_i.in_chan) == g)),
      .waddr_i (map_waddr),
      .wdata_i (in_data_i.elem_value),
      .raddr_i (map_raddr),
      .rdata_o (map_rd[g])
    );
    c2d_ram #(.Width(16), .Depth(WtDepth)) u_wt_ram (
      .clk_i   (clk_i),
      .we_i    (wt_we && (int'(in_data_i.in_chan) == g)),
      .waddr_i (wt_waddr),
      .wdata_i (in_data_i.elem_value),
      .raddr_i (widx_q),
      .rdata_o (wt_rd[g])
    );
  end

  // ---- Pipeline control flags ----
  logic v1_q, f1_q, l1_q, v2_q, f2_q, l2_q, v3_q, f3_q, l3_q, v4_q, l4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; f1_q <= 1'b0; l1_q <= 1'b0;
      v2_q <= 1'b0; f2_q <= 1'b0; l2_q <= 1'b0;
      v3_q <= 1'b0; f3_q <= 1'b0; l3_q <= 1'b0;
      v4_q <= 1'b0; l4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      f1_q <= cmd_i.first;
      l1_q <= cmd_i.last;
      v2_q <= v1_q; f2_q <= f1_q; l2_q <= l1_q;
      v3_q <= v2_q; f3_q <= f2_q; l3_q <= l2_q;
      v4_q <= v3_q && l3_q;
      l4_q <= v3_q && l3_q;
    end
  end

  // Tap in range flag follows the read data.
  logic ok1_q;
  always_ff @(posedge clk_i) begin
    ok1_q <= tap_ok;
  end

  // ---- Products, one per input channel ----
  logic signed [31:0] prod_q [InChannels];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < InChannels; i++) begin
      prod_q[i] <= ok1_q ? (map_rd[i] * wt_rd[i]) : 32'sd0;
    end
  end

  // ---- Channel sum ----
  logic signed [SumW-1:0] tsum, tsum_q;
  always_comb begin
    tsum = '0;
    for (int i = 0; i < InChannels; i++) begin
      tsum = tsum + SumW'(prod_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    tsum_q <= tsum;
  end

  // ---- Accumulator ----
  logic signed [47:0] acc_q;
  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      acc_q <= (f3_q ? 48'sd0 : acc_q) + 48'(tsum_q);
    end
  end

  // ---- Round to nearest and saturate ----
  logic signed [47:0] rnd;
  logic signed [39:0] quo;
  logic signed [15:0] sat;
  always_comb begin
    rnd = acc_q + 48'sd128;
    quo = 40'(rnd >>> 8);
    if (quo > 40'sd32767) begin
      sat = 16'sh7fff;
    end else if (quo < -40'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = 16'(quo);
    end
  end

  // ---- Output register ----
  logic     out_valid_q;
  c2d_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (v4_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v4_q) begin
      out_q.res_row   <= prow_q;
      out_q.res_col   <= pcol_q;
      out_q.res_chan  <= 3'(chan_q);
      out_q.sum_value <= sat;
      out_q.last      <= lastch_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign status_o.done     = l4_q;
  assign status_o.out_busy = out_valid_q;

endmodule
